// ----- hdl/rop_pkg.sv -----
// Package for the rectangle obstacle min-gap path block.
// Holds cost constants, the controller state type and the cell control struct.
// No dependencies.
`default_nettype none
package rop_pkg;
  localparam int MAX_RECTS_DEF  = 256;
  localparam int COORD_BITS_DEF = 21;
  localparam int Y_W            = 20;
  localparam int COST_W         = 22;
  localparam logic [COST_W-1:0] COST_MAX = 22'h3FFFFE;
  localparam logic [COST_W-1:0] COST_INF = 22'h3FFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_RELAX
  } rop_state_t;

  typedef struct packed {
    logic shift;
    logic init;
    logic relax;
    logic clear;
  } rop_ctl_t;
endpackage
`default_nettype wire

// ----- hdl/rop_cell.sv -----
// One chain cell: holds a rectangle, its path cost and done bit, and one
// stage of the minimum scan. Depends on rop_pkg.
`default_nettype none
module rop_cell import rop_pkg::*; #(
  parameter int CW  = COORD_BITS_DEF,
  parameter int IW  = 8,
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rop_ctl_t          ctl,
  input  wire logic [Y_W-1:0]    cw,
  input  wire logic [COST_W-1:0] cur_cost,
  input  wire logic [IW-1:0]     cur_idx,
  input  wire logic [CW-1:0]     cur_lx,
  input  wire logic [Y_W-1:0]    cur_by,
  input  wire logic [CW-1:0]     cur_rx,
  input  wire logic [Y_W-1:0]    cur_ty,
  input  wire logic              sh_valid_in,
  input  wire logic [CW-1:0]     sh_lx_in,
  input  wire logic [Y_W-1:0]    sh_by_in,
  input  wire logic [CW-1:0]     sh_rx_in,
  input  wire logic [Y_W-1:0]    sh_ty_in,
  output logic                   sh_valid_out,
  output logic [CW-1:0]          sh_lx_out,
  output logic [Y_W-1:0]         sh_by_out,
  output logic [CW-1:0]          sh_rx_out,
  output logic [Y_W-1:0]         sh_ty_out,
  input  wire logic              sc_hit_in,
  input  wire logic [COST_W-1:0] sc_cost_in,
  input  wire logic [IW-1:0]     sc_idx_in,
  input  wire logic [CW-1:0]     sc_lx_in,
  input  wire logic [Y_W-1:0]    sc_by_in,
  input  wire logic [CW-1:0]     sc_rx_in,
  input  wire logic [Y_W-1:0]    sc_ty_in,
  output logic                   sc_hit_out,
  output logic [COST_W-1:0]      sc_cost_out,
  output logic [IW-1:0]          sc_idx_out,
  output logic [CW-1:0]          sc_lx_out,
  output logic [Y_W-1:0]         sc_by_out,
  output logic [CW-1:0]          sc_rx_out,
  output logic [Y_W-1:0]         sc_ty_out
);
  localparam int GW = (CW + 1 > Y_W + 1) ? CW + 1 : Y_W + 1;
  localparam int SW = ((GW > COST_W) ? GW : COST_W) + 1;

  logic              valid;
  logic [CW-1:0]     lx;
  logic [Y_W-1:0]    by;
  logic [CW-1:0]     rx;
  logic [Y_W-1:0]    ty;
  logic [COST_W-1:0] cost;
  logic              done;

  logic signed [CW:0]  dx1, dx2;
  logic signed [Y_W:0] dy1, dy2, dtop;
  logic [GW-1:0]       g1, g2, g3, g4, gmax;
  logic [SW-1:0]       sum;
  logic [COST_W-1:0]   relax_cost;
  logic [COST_W-1:0]   init_cost;
  logic                cand;
  logic                take_in;

  assign dx1  = $signed({lx[CW-1], lx}) - $signed({cur_rx[CW-1], cur_rx});
  assign dx2  = $signed({cur_lx[CW-1], cur_lx}) - $signed({rx[CW-1], rx});
  assign dy1  = $signed({1'b0, by}) - $signed({1'b0, cur_ty});
  assign dy2  = $signed({1'b0, cur_by}) - $signed({1'b0, ty});
  assign dtop = $signed({1'b0, cw}) - $signed({1'b0, ty});

  always_comb begin
    g1 = dx1[CW] ? '0 : GW'($unsigned(dx1));
    g2 = dx2[CW] ? '0 : GW'($unsigned(dx2));
    g3 = dy1[Y_W] ? '0 : GW'($unsigned(dy1));
    g4 = dy2[Y_W] ? '0 : GW'($unsigned(dy2));
    gmax = g1;
    if (g2 > gmax) gmax = g2;
    if (g3 > gmax) gmax = g3;
    if (g4 > gmax) gmax = g4;
    sum = SW'(cur_cost) + SW'(gmax);
    relax_cost = (sum > SW'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
    init_cost = dtop[Y_W] ? '0 : COST_W'($unsigned(dtop[Y_W-1:0]));
  end

  assign cand    = valid && !done;
  assign take_in = sc_hit_in && (!cand || sc_cost_in <= cost);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= sh_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      lx <= sh_lx_in;
      by <= sh_by_in;
      rx <= sh_rx_in;
      ty <= sh_ty_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      cost <= init_cost;
      done <= 1'b0;
    end else if (ctl.relax) begin
      if (cur_idx == IW'(IDX)) begin
        done <= 1'b1;
      end else if (cand && relax_cost < cost) begin
        cost <= relax_cost;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      sc_hit_out  <= 1'b1;
      sc_cost_out <= sc_cost_in;
      sc_idx_out  <= sc_idx_in;
      sc_lx_out   <= sc_lx_in;
      sc_by_out   <= sc_by_in;
      sc_rx_out   <= sc_rx_in;
      sc_ty_out   <= sc_ty_in;
    end else begin
      sc_hit_out  <= cand;
      sc_cost_out <= cost;
      sc_idx_out  <= IW'(IDX);
      sc_lx_out   <= lx;
      sc_by_out   <= by;
      sc_rx_out   <= rx;
      sc_ty_out   <= ty;
    end
  end

  assign sh_valid_out = valid;
  assign sh_lx_out    = lx;
  assign sh_by_out    = by;
  assign sh_rx_out    = rx;
  assign sh_ty_out    = ty;
endmodule
`default_nettype wire

// ----- hdl/rect_obstacle_min_gap_path.sv -----
// A last beat starts a search: an init step, then up to rect_count + 1 rounds,
// each a scan down the cell chain plus a relax, then the registered result.
// Throughput: one beat per cycle while loading; one search at a time.
// Result: done high for exactly one cycle; the receiver cannot stall.
// Reset (rst, synchronous): store empty, corridor_width 0, controller idle.
`default_nettype none
module rect_obstacle_min_gap_path import rop_pkg::*; #(
  parameter int MAX_RECTS  = MAX_RECTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] left_x,
  input  wire logic [Y_W-1:0]               bottom_y,
  input  wire logic signed [COORD_BITS-1:0] right_x,
  input  wire logic [Y_W-1:0]               top_y,
  input  wire logic                         has_rect,
  input  wire logic                         last_rect,
  input  wire logic                         cfg_we,
  input  wire logic [Y_W-1:0]               cfg_data,
  output logic                              done,
  output logic [Y_W-1:0]                    min_gap_cost
);
  localparam int CW   = COORD_BITS;
  localparam int N    = MAX_RECTS;
  localparam int IW   = (N > 1) ? $clog2(N) : 1;
  localparam int CNTW = $clog2(N + 1);

  rop_state_t state, state_next;
  rop_ctl_t   ctl;

  logic [Y_W-1:0]    cw;
  logic [CNTW-1:0]   cnt;
  logic [IW-1:0]     scnt;
  logic [COST_W-1:0] bot_cost;
  logic              accept, store_it, finish, go;
  logic [COST_W:0]   bot_sum;
  logic [COST_W-1:0] bot_relax;

  logic          shv [N+1];
  logic [CW-1:0] shlx [N+1];
  logic [Y_W-1:0] shby [N+1];
  logic [CW-1:0] shrx [N+1];
  logic [Y_W-1:0] shty [N+1];
  logic              sch [N+1];
  logic [COST_W-1:0] scc [N+1];
  logic [IW-1:0]     sci [N+1];
  logic [CW-1:0]     sclx [N+1];
  logic [Y_W-1:0]    scby [N+1];
  logic [CW-1:0]     scrx [N+1];
  logic [Y_W-1:0]    scty [N+1];

  assign accept   = start && !busy;
  assign store_it = accept && has_rect && (cnt != CNTW'(N));
  assign finish   = (state == ST_RELAX) && !(sch[N] && scc[N] < bot_cost);
  assign go       = (state == ST_RELAX) && sch[N] && scc[N] < bot_cost;

  assign shv[0]  = 1'b1;
  assign shlx[0] = left_x;
  assign shby[0] = bottom_y;
  assign shrx[0] = right_x;
  assign shty[0] = top_y;
  assign sch[0]  = 1'b0;
  assign scc[0]  = COST_INF;
  assign sci[0]  = '0;
  assign sclx[0] = '0;
  assign scby[0] = '0;
  assign scrx[0] = '0;
  assign scty[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rop_cell #(.CW(CW), .IW(IW), .IDX(i)) u_cell (
      .clk, .rst, .ctl, .cw,
      .cur_cost(scc[N]), .cur_idx(sci[N]), .cur_lx(sclx[N]), .cur_by(scby[N]),
      .cur_rx(scrx[N]), .cur_ty(scty[N]),
      .sh_valid_in(shv[i]), .sh_lx_in(shlx[i]), .sh_by_in(shby[i]),
      .sh_rx_in(shrx[i]), .sh_ty_in(shty[i]),
      .sh_valid_out(shv[i+1]), .sh_lx_out(shlx[i+1]), .sh_by_out(shby[i+1]),
      .sh_rx_out(shrx[i+1]), .sh_ty_out(shty[i+1]),
      .sc_hit_in(sch[i]), .sc_cost_in(scc[i]), .sc_idx_in(sci[i]),
      .sc_lx_in(sclx[i]), .sc_by_in(scby[i]), .sc_rx_in(scrx[i]), .sc_ty_in(scty[i]),
      .sc_hit_out(sch[i+1]), .sc_cost_out(scc[i+1]), .sc_idx_out(sci[i+1]),
      .sc_lx_out(sclx[i+1]), .sc_by_out(scby[i+1]), .sc_rx_out(scrx[i+1]),
      .sc_ty_out(scty[i+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && last_rect) state_next = ST_INIT;
      ST_INIT:  state_next = ST_SCAN;
      ST_SCAN:  if (scnt == IW'(N - 1)) state_next = ST_RELAX;
      ST_RELAX: state_next = finish ? ST_IDLE : ST_SCAN;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
    ctl  = '0;
    ctl.shift = store_it;
    ctl.init  = (state == ST_INIT);
    ctl.relax = go;
    ctl.clear = finish;
  end

  always_comb begin
    bot_sum   = (COST_W+1)'(scc[N]) + (COST_W+1)'(scby[N]);
    bot_relax = (bot_sum > (COST_W+1)'(COST_MAX)) ? COST_MAX : bot_sum[COST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cw    <= '0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) cw <= cfg_data;
      if (finish) cnt <= '0;
      else if (store_it) cnt <= cnt + 1'b1;
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (state != ST_SCAN) scnt <= '0;
    else scnt <= scnt + 1'b1;
    if (state == ST_INIT) bot_cost <= COST_W'(cw);
    else if (go && bot_relax < bot_cost) bot_cost <= bot_relax;
    if (finish) begin
      min_gap_cost <= (bot_cost > COST_W'({Y_W{1'b1}})) ? {Y_W{1'b1}} : bot_cost[Y_W-1:0];
    end
  end
endmodule
`default_nettype wire

// ----- hdl/rop_checker.sv -----
// Port-level checker for rect_obstacle_min_gap_path, bound to the top level.
// Depends only on the handshake ports of the top level.
`default_nettype none
module rop_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic last_rect,
  input wire logic done
);
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one beat");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last_rect |=> busy)
    else $error("last beat did not start a search");
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && last_rect))
    else $error("busy rose without a last beat");
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a search");
endmodule

bind rect_obstacle_min_gap_path rop_checker u_rop_checker (.*);
`default_nettype wire

// ----- tb/rect_obstacle_min_gap_path_test.sv -----
// Testbench for rect_obstacle_min_gap_path: loads rectangle sets, predicts the
// least top-to-bottom clearance cost and checks every done beat against it.
// Depends on rop_pkg and the rect_obstacle_min_gap_path RTL.
`timescale 1ns / 100ps
module rect_obstacle_min_gap_path_test;
  import rop_pkg::*;

  localparam int SLOTS      = 256;
  localparam int CYCLE_CAP  = 3000000;
  localparam int SHOWN_ERRS = 10;

  typedef struct {
    logic signed [20:0] lx;
    logic [Y_W-1:0]     by;
    logic signed [20:0] rx;
    logic [Y_W-1:0]     ty;
    logic               has;
    logic               fin;
  } rect_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [20:0] left_x = '0;
  logic [Y_W-1:0] bottom_y = '0;
  logic signed [20:0] right_x = '0;
  logic [Y_W-1:0] top_y = '0;
  logic has_rect = 1'b0;
  logic last_rect = 1'b0;
  logic cfg_we = 1'b0;
  logic [Y_W-1:0] cfg_data = '0;
  logic done;
  logic [Y_W-1:0] min_gap_cost;

  rect_beat_t pending_beats[$];
  logic [Y_W-1:0] gap_expect_q[$];
  rect_beat_t drv_beat;

  longint corr_w;
  longint rect_lx[SLOTS], rect_by[SLOTS], rect_rx[SLOTS], rect_ty[SLOTS];
  int held_rects;
  int idle_pct;
  int errors;
  int beats_taken, costs_checked, items_queued, width_writes;
  int cycles;

  rect_obstacle_min_gap_path DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .left_x(left_x), .bottom_y(bottom_y), .right_x(right_x), .top_y(top_y),
    .has_rect(has_rect), .last_rect(last_rect),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .done(done), .min_gap_cost(min_gap_cost)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clearance(int a, int b, int n);
    longint d;
    int t;
    if (a > b) begin
      t = a; a = b; b = t;
    end
    if (a == 0 && b == n + 1) return corr_w;
    if (a == 0) begin
      d = corr_w - rect_ty[b-1];
      return (d > 0) ? d : 0;
    end
    if (b == n + 1) return rect_by[a-1];
    a--; b--;
    d = 0;
    if (rect_lx[a] - rect_rx[b] > d) d = rect_lx[a] - rect_rx[b];
    if (rect_lx[b] - rect_rx[a] > d) d = rect_lx[b] - rect_rx[a];
    if (rect_by[a] - rect_ty[b] > d) d = rect_by[a] - rect_ty[b];
    if (rect_by[b] - rect_ty[a] > d) d = rect_by[b] - rect_ty[a];
    return d;
  endfunction

  function automatic logic [Y_W-1:0] shortest_gap();
    longint cost[SLOTS+2];
    bit fixed[SLOTS+2];
    int n, total, cur;
    longint best, sum;
    n = held_rects;
    total = n + 2;
    for (int i = 0; i < total; i++) begin
      cost[i] = longint'(COST_INF);
      fixed[i] = 1'b0;
    end
    cost[0] = 0;
    for (int r = 0; r < total; r++) begin
      cur = total;
      best = longint'(COST_INF);
      for (int i = 0; i < total; i++)
        if (!fixed[i] && cost[i] < best) begin
          best = cost[i];
          cur = i;
        end
      if (cur >= total) break;
      fixed[cur] = 1'b1;
      for (int i = 0; i < total; i++) begin
        if (i == cur || fixed[i]) continue;
        sum = cost[cur] + clearance(cur, i, n);
        if (sum > longint'(COST_MAX)) sum = longint'(COST_MAX);
        if (sum < cost[i]) cost[i] = sum;
      end
    end
    return (cost[n+1] > 64'hFFFFF) ? 20'hFFFFF : cost[n+1][Y_W-1:0];
  endfunction

  function automatic void take_beat(rect_beat_t b);
    if (b.has && held_rects < SLOTS) begin
      rect_lx[held_rects] = longint'(b.lx);
      rect_by[held_rects] = longint'(b.by);
      rect_rx[held_rects] = longint'(b.rx);
      rect_ty[held_rects] = longint'(b.ty);
      held_rects++;
    end
    if (b.fin) begin
      gap_expect_q.push_back(shortest_gap());
      held_rects = 0;
    end
  endfunction

  // driver: hold a beat until accepted, then advance
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
        drv_beat = pending_beats.pop_front();
        start <= 1'b1;
        left_x <= drv_beat.lx;
        bottom_y <= drv_beat.by;
        right_x <= drv_beat.rx;
        top_y <= drv_beat.ty;
        has_rect <= drv_beat.has;
        last_rect <= drv_beat.fin;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on accepted beats, check on done
  always @(posedge clk) begin
    rect_beat_t seen;
    logic [Y_W-1:0] want;
    if (!rst) begin
      if (start && !busy) begin
        seen.lx = left_x; seen.by = bottom_y; seen.rx = right_x; seen.ty = top_y;
        seen.has = has_rect; seen.fin = last_rect;
        take_beat(seen);
        beats_taken++;
      end
      if (done) begin
        if (gap_expect_q.size() == 0) begin
          errors++;
          if (errors <= SHOWN_ERRS)
            $display("ERROR: unexpected cost beat %0d", min_gap_cost);
        end else begin
          want = gap_expect_q.pop_front();
          costs_checked++;
          if (min_gap_cost !== want) begin
            errors++;
            if (errors <= SHOWN_ERRS)
              $display("ERROR: min_gap_cost expected %0d got %0d", want, min_gap_cost);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_beat(int lx, int by, int rx, int ty, bit has, bit fin);
    rect_beat_t b;
    b.lx = 21'(lx); b.by = Y_W'(by); b.rx = 21'(rx); b.ty = Y_W'(ty);
    b.has = has; b.fin = fin;
    pending_beats.push_back(b);
    items_queued++;
  endtask

  task automatic drain();
    wait (pending_beats.size() == 0 && !start && gap_expect_q.size() == 0);
    repeat (20) @(posedge clk);
    wait (!busy);
    @(posedge clk);
  endtask

  task automatic write_width(logic [Y_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    corr_w = longint'(v);
    width_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_rect(bit wide, bit fin, bit has);
    int lx, rx, by, ty, w;
    if (wide) begin
      lx = int'($signed(21'($urandom))); rx = int'($signed(21'($urandom)));
      by = $urandom & 20'hFFFFF;   ty = $urandom & 20'hFFFFF;
    end else begin
      w = (corr_w > 0) ? int'(corr_w) : 100;
      lx = $urandom_range(0, 4000) - 2000;
      rx = lx + $urandom_range(0, 600);
      by = $urandom_range(0, w);
      ty = by + $urandom_range(0, w / 3 + 1);
      if ($urandom_range(19) == 0) begin
        rx = lx - $urandom_range(1, 300);
        ty = (by > 5) ? by - 5 : 0;
      end
      if (ty > 20'hFFFFF) ty = 20'hFFFFF;
    end
    add_beat(lx, by, rx, ty, has, fin);
  endtask

  task automatic random_set(int n);
    bit wide;
    wide = ($urandom_range(9) == 0);
    for (int i = 0; i < n; i++)
      random_rect(wide, 1'b0, $urandom_range(9) != 0);
    random_rect(wide, 1'b1, $urandom_range(1) != 0);
  endtask

  task automatic random_phase(int pct, int count);
    int stop, n;
    idle_pct = pct;
    stop = items_queued + count;
    while (items_queued < stop) begin
      if ($urandom_range(29) == 0)
        write_width(Y_W'($urandom_range(3) == 0 ? $urandom & 20'hFFFFF
                                                 : $urandom_range(1, 5000)));
      n = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      random_set(n);
    end
  endtask

  initial begin
    corr_w = 0;
    held_rects = 0;
    idle_pct = 18;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_width(1000);
    add_beat(0, 0, 0, 0, 1'b0, 1'b1);                 // empty set
    add_beat(-10, 200, 10, 800, 1'b1, 1'b1);          // one rect inside
    add_beat(-10, 300, 10, 1500, 1'b1, 1'b1);         // sticks out above the top wall
    add_beat(50, 900, -50, 100, 1'b1, 1'b1);          // inverted
    add_beat(0, 100, 100, 600, 1'b1, 1'b0);
    add_beat(0, 0, 0, 0, 1'b0, 1'b0);                 // no rect mid-set
    add_beat(120, 500, 300, 1000, 1'b1, 1'b0);
    add_beat(50, 550, 60, 560, 1'b1, 1'b1);
    add_beat(-1048576, 0, 1048575, 20'hFFFFF, 1'b1, 1'b1);
    add_beat(1048575, 20'hFFFFF, -1048576, 0, 1'b1, 1'b0);
    add_beat(-1048576, 0, -1048576, 0, 1'b1, 1'b1);

    write_width(0);
    add_beat(0, 0, 10, 0, 1'b1, 1'b1);
    random_set(3);

    write_width(20'hFFFFF);
    add_beat(0, 0, 0, 0, 1'b0, 1'b1);
    add_beat(-5, 10, 5, 20'hFFFFE, 1'b1, 1'b1);
    for (int i = 0; i < SLOTS + 3; i++)               // overflow the store
      random_rect(1'b1, i == SLOTS + 2, 1'b1);
    random_set(5);

    write_width(1);
    random_set(4);
    write_width(2000);

    random_phase(18, 530);
    write_width(700);
    random_phase(64, 530);
    write_width(3000);
    random_phase(0, 530);

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d beats, %0d path costs, %0d width writes, full-store and overflow",
             beats_taken, costs_checked, width_writes);
    $display("directed extremes, empty and inverted sets, three sender idle mixes");
    if (errors == 0 && gap_expect_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d costs outstanding", errors, gap_expect_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/rop_pkg.sv
hdl/rop_cell.sv
hdl/rect_obstacle_min_gap_path.sv
hdl/rop_checker.sv
tb/rect_obstacle_min_gap_path_test.sv
